[design/crm_pkg.sv]
`default_nettype none

package crm_pkg;

  // Register and field widths
  localparam int CFG_W     = 16;
  localparam int MOD_WIDTH = 16;
  localparam int VALUE_W   = 17;
  localparam int BASE_W    = VALUE_W + 1;
  localparam int BMAG_W    = VALUE_W;
  localparam int RES_W     = 17;
  localparam int CODE_W    = 18;
  localparam int IDX_W     = 2;

  // Offset between character codes and bases
  localparam int CODE_OFFSET = 96;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [IDX_W-1:0] REG_ENC_EXP = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEC_EXP = 2'd2;

  // Reset values
  localparam logic [CFG_W-1:0] MODULUS_RST = 16'd3233;
  localparam logic [CFG_W-1:0] ENC_EXP_RST = 16'd17;
  localparam logic [CFG_W-1:0] DEC_EXP_RST = 16'd2753;

  // Commands
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

[design/char_rsa_modexp_core.sv]
`default_nettype none

// Textbook RSA on one character code or residue per item.
// Input stream: tuser carries the command (0 encrypt, 1 decrypt), tdata the
// signed 17-bit value. An encrypt item uses base = value - 96 and the
// encrypt exponent, a decrypt item uses base = value and the decrypt exponent.
// The result r starts at 1 and takes r = (r * base) rem modulus once per unit
// of the exponent; the remainder truncates toward zero.
// Output stream: tdata carries residue and residue + 96.
// Registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i; the user must
// write them only while idle, as the block itself does not enforce this.
// Each multiply-and-reduce step passes through the multiplier state, then a
// restoring remainder unit that retires one product bit a cycle. A zero modulus
// skips the remainder unit, and a zero exponent skips the steps.
// The block accepts one item at a time; tready is high only while idle.
// A finished result sits in the output register; the next item may be taken
// while it waits, and its own result holds inside until the register frees.
// Reset returns the registers to 3233, 17 and 2753 and empties the block.
module char_rsa_modexp_core
  import crm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration write port
  input  wire logic              cfg_we_i,
  input  wire logic [IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  // Input items
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [23:0]       s_axis_tdata_i,  // [16:0] value
  input  wire logic              s_axis_tuser_i,  // [0] command
  // Result items
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [39:0]            m_axis_tdata_o   // [16:0] residue, [34:17] out_code
);

  localparam int P_W   = MOD_WIDTH + BMAG_W;
  localparam int CNT_W = $clog2(P_W + 1);
  localparam int R_W   = (MOD_WIDTH + 2 > CODE_W) ? MOD_WIDTH + 2 : CODE_W;

  // Configuration registers
  logic [CFG_W-1:0] mod_q, enc_exp_q, dec_exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q     <= MODULUS_RST;
      enc_exp_q <= ENC_EXP_RST;
      dec_exp_q <= DEC_EXP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODULUS: mod_q     <= cfg_wdata_i;
        REG_ENC_EXP: enc_exp_q <= cfg_wdata_i;
        REG_DEC_EXP: dec_exp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [MOD_WIDTH-1:0] n;
  logic                 n_zero;
  assign n      = MOD_WIDTH'(mod_q);
  assign n_zero = (n == '0);

  // Sequencer and datapath state
  state_e               state_q, state_d;
  logic [CFG_W-1:0]     exp_q, exp_d;
  logic                 bsign_q, bsign_d;
  logic [BMAG_W-1:0]    bmag_q, bmag_d;
  logic                 rsign_q, rsign_d;
  logic [MOD_WIDTH-1:0] rmag_q, rmag_d;
  logic                 psign_q, psign_d;
  logic [P_W-1:0]       prod_q, prod_d;
  logic [MOD_WIDTH-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [RES_W-1:0]     res_q, res_d;
  logic [CODE_W-1:0]    code_q, code_d;

  // Base from the input item
  logic                 in_accept;
  logic [BASE_W-1:0]    v_ext, base;
  logic [BASE_W-1:0]    base_neg;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign v_ext     = BASE_W'(signed'(s_axis_tdata_i[VALUE_W-1:0]));
  assign base      = (s_axis_tuser_i == CMD_ENCRYPT) ?
                     v_ext - BASE_W'(CODE_OFFSET) : v_ext;
  assign base_neg  = -base;

  // Shared multiplier and one-bit restoring remainder step
  logic [P_W-1:0]       mul_res;
  logic [MOD_WIDTH:0]   shifted, diff;
  logic                 ge;
  logic [MOD_WIDTH-1:0] rem_step;
  assign mul_res  = {{BMAG_W{1'b0}}, rmag_q} * {{MOD_WIDTH{1'b0}}, bmag_q};
  assign shifted  = {rem_q, prod_q[P_W-1]};
  assign diff     = shifted - {1'b0, n};
  assign ge       = (shifted >= {1'b0, n});
  assign rem_step = ge ? diff[MOD_WIDTH-1:0] : shifted[MOD_WIDTH-1:0];

  // Final signed residue and output code
  logic [R_W-1:0] r_signed, r_code;
  assign r_signed = rsign_q ? -R_W'(rmag_q) : R_W'(rmag_q);
  assign r_code   = r_signed + R_W'(CODE_OFFSET);

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    bsign_d     = bsign_q;
    bmag_d      = bmag_q;
    rsign_d     = rsign_q;
    rmag_d      = rmag_q;
    psign_d     = psign_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    code_d      = code_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          bsign_d = base[BASE_W-1];
          bmag_d  = base[BASE_W-1] ? base_neg[BMAG_W-1:0] : base[BMAG_W-1:0];
          exp_d   = (s_axis_tuser_i == CMD_ENCRYPT) ? enc_exp_q : dec_exp_q;
          rsign_d = 1'b0;
          rmag_d  = MOD_WIDTH'(1);
          state_d = (exp_d == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (n_zero) begin
          // Zero divisor: the step gives 0
          rmag_d  = '0;
          rsign_d = 1'b0;
          exp_d   = exp_q - CFG_W'(1);
          state_d = (exp_q == CFG_W'(1)) ? ST_DONE : ST_MUL;
        end else begin
          prod_d  = mul_res;
          psign_d = rsign_q ^ bsign_q;
          rem_d   = '0;
          cnt_d   = CNT_W'(P_W);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        prod_d = prod_q << 1;
        rem_d  = rem_step;
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          rmag_d  = rem_step;
          rsign_d = psign_q && (rem_step != '0);
          exp_d   = exp_q - CFG_W'(1);
          state_d = (exp_q == CFG_W'(1)) ? ST_DONE : ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_d       = r_signed[RES_W-1:0];
          code_d      = r_code[CODE_W-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    exp_q   <= exp_d;
    bsign_q <= bsign_d;
    bmag_q  <= bmag_d;
    rsign_q <= rsign_d;
    rmag_q  <= rmag_d;
    psign_q <= psign_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    code_q  <= code_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, code_q, res_q};

  // Partial remainder stays below the modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < n))
    else $error("partial remainder not reduced");

  // Steps run only with exponent units left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MUL) || (state_q == ST_DIV)) |-> (exp_q != '0))
    else $error("step with exhausted exponent");

  // An accepted item leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != ST_IDLE))
    else $error("accepted item did not start");

  // A new result is loaded only from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside done state");

  // Division counter is live while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q != '0))
    else $error("remainder counter underflow");

endmodule

`default_nettype wire

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import crm_pkg::*;

  // Index that maps to no register
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int RAND_ITEMS       = 1450;
  localparam int NUM_PHASES       = 12;
  localparam int HOLD_PHASE       = 2;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int WATCHDOG_LIMIT   = 300000;
  localparam int TAIL_CYCLES      = 60;
  localparam int MAX_REPORTS      = 40;

  typedef struct packed {
    logic signed [RES_W-1:0]  residue;
    logic signed [CODE_W-1:0] code;
  } modexp_out_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [IDX_W-1:0] reg_idx;
    logic             cmd;
    int               value;   // item value, or register data on a write row
    bit               typed;   // expected result given in the row
    int               t_res;
    int               t_code;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata   = '0;
  logic              s_tuser   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [39:0]       m_tdata;

  // Sideband that travels with the offered item
  logic              tag_typed = 1'b0;
  modexp_out_t       tag_out   = '0;

  // Register shadow, updated on each write
  logic [CFG_W-1:0]  cur_modulus = MODULUS_RST;
  logic [CFG_W-1:0]  cur_enc_exp = ENC_EXP_RST;
  logic [CFG_W-1:0]  cur_dec_exp = DEC_EXP_RST;

  modexp_out_t       awaited_q [$];
  int                error_count  = 0;
  int                quiet_cycles = 0;
  int                tx_idle_pct  = 0;
  int                rx_idle_pct  = 0;
  bit                hold_req     = 1'b0;

  dir_row_t directed [$] = '{
    // reset keys: classic 3233 / 17 / 2753 pair
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 161,    1'b1, 2790,   2886},
    '{ROW_ITEM, REG_MODULUS, CMD_DECRYPT, 2790,   1'b1, 65,     161},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 96,     1'b1, 0,      96},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 0,      1'b0, 0,      0},
    // spare index must leave every register alone
    '{ROW_CFG,  REG_DEC_EXP, CMD_ENCRYPT, 3,      1'b0, 0,      0},
    '{ROW_CFG,  REG_SPARE,   CMD_ENCRYPT, 65535,  1'b0, 0,      0},
    '{ROW_ITEM, REG_MODULUS, CMD_DECRYPT, 2,      1'b1, 8,      104},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 98,     1'b1, 1752,   1848},
    // widest modulus, single step: field corners
    '{ROW_CFG,  REG_MODULUS, CMD_ENCRYPT, 65535,  1'b0, 0,      0},
    '{ROW_CFG,  REG_ENC_EXP, CMD_ENCRYPT, 1,      1'b0, 0,      0},
    '{ROW_CFG,  REG_DEC_EXP, CMD_ENCRYPT, 1,      1'b0, 0,      0},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 255,    1'b1, 159,    255},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 65535,  1'b1, 65439,  65535},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, -65536, 1'b1, -97,    -1},
    '{ROW_ITEM, REG_MODULUS, CMD_DECRYPT, -65536, 1'b1, -1,     95},
    '{ROW_ITEM, REG_MODULUS, CMD_DECRYPT, 65535,  1'b1, 0,      96},
    '{ROW_ITEM, REG_MODULUS, CMD_DECRYPT, 12345,  1'b0, 0,      0},
    // zero exponents give one
    '{ROW_CFG,  REG_ENC_EXP, CMD_ENCRYPT, 0,      1'b0, 0,      0},
    '{ROW_CFG,  REG_DEC_EXP, CMD_ENCRYPT, 0,      1'b0, 0,      0},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 200,    1'b1, 1,      97},
    '{ROW_ITEM, REG_MODULUS, CMD_DECRYPT, -777,   1'b1, 1,      97},
    // zero modulus with the largest exponents
    '{ROW_CFG,  REG_MODULUS, CMD_ENCRYPT, 0,      1'b0, 0,      0},
    '{ROW_CFG,  REG_ENC_EXP, CMD_ENCRYPT, 65535,  1'b0, 0,      0},
    '{ROW_CFG,  REG_DEC_EXP, CMD_ENCRYPT, 65535,  1'b0, 0,      0},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 100,    1'b1, 0,      96},
    '{ROW_ITEM, REG_MODULUS, CMD_DECRYPT, 5,      1'b1, 0,      96},
    // modulus of one
    '{ROW_CFG,  REG_MODULUS, CMD_ENCRYPT, 1,      1'b0, 0,      0},
    '{ROW_CFG,  REG_ENC_EXP, CMD_ENCRYPT, 5,      1'b0, 0,      0},
    '{ROW_CFG,  REG_DEC_EXP, CMD_ENCRYPT, 2,      1'b0, 0,      0},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 150,    1'b1, 0,      96},
    '{ROW_ITEM, REG_MODULUS, CMD_DECRYPT, -3,     1'b1, 0,      96},
    // smallest legal modulus, a negative base
    '{ROW_CFG,  REG_MODULUS, CMD_ENCRYPT, 2,      1'b0, 0,      0},
    '{ROW_CFG,  REG_ENC_EXP, CMD_ENCRYPT, 3,      1'b0, 0,      0},
    '{ROW_CFG,  REG_DEC_EXP, CMD_ENCRYPT, 4,      1'b0, 0,      0},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 1,      1'b0, 0,      0},
    '{ROW_ITEM, REG_MODULUS, CMD_DECRYPT, 7,      1'b0, 0,      0},
    // zero modulus, zero exponent still gives one
    '{ROW_CFG,  REG_MODULUS, CMD_ENCRYPT, 0,      1'b0, 0,      0},
    '{ROW_CFG,  REG_ENC_EXP, CMD_ENCRYPT, 0,      1'b0, 0,      0},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 50,     1'b1, 1,      97},
    // code outside 0..255 and negative cubes
    '{ROW_CFG,  REG_MODULUS, CMD_ENCRYPT, 1000,   1'b0, 0,      0},
    '{ROW_CFG,  REG_ENC_EXP, CMD_ENCRYPT, 3,      1'b0, 0,      0},
    '{ROW_CFG,  REG_DEC_EXP, CMD_ENCRYPT, 3,      1'b0, 0,      0},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 0,      1'b0, 0,      0},
    '{ROW_ITEM, REG_MODULUS, CMD_DECRYPT, -500,   1'b0, 0,      0},
    '{ROW_ITEM, REG_MODULUS, CMD_ENCRYPT, 256,    1'b0, 0,      0}
  };

  char_rsa_modexp_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [16:0] value
    .s_axis_tuser_i  (s_tuser),   // [0] command
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // [16:0] residue, [34:17] out_code
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Raise the base to the exponent by repeated multiply and truncating remainder
  function automatic modexp_out_t modexp_predict(logic cmd,
                                                 logic signed [VALUE_W-1:0] value,
                                                 logic [CFG_W-1:0] n,
                                                 logic [CFG_W-1:0] e_enc,
                                                 logic [CFG_W-1:0] e_dec);
    longint      base;
    longint      divisor;
    longint      r;
    int unsigned steps;
    modexp_out_t res;
    base    = (cmd == CMD_ENCRYPT) ? longint'(value) - CODE_OFFSET : longint'(value);
    steps   = (cmd == CMD_ENCRYPT) ? e_enc : e_dec;
    divisor = longint'(n);
    r       = 1;
    for (int unsigned k = 0; k < steps; k++) begin
      // a zero divisor answers zero
      r = (divisor == 0) ? 0 : (r * base) % divisor;
    end
    res.residue = RES_W'(r);
    res.code    = CODE_W'(r + CODE_OFFSET);
    return res;
  endfunction

  // Pick an item value: mostly in range, some field corners and raw bits
  function automatic logic signed [VALUE_W-1:0] random_value(logic cmd,
                                                             logic [CFG_W-1:0] n);
    int pick;
    int mag;
    pick = $urandom_range(0, 9);
    if (pick >= 8) return VALUE_W'($urandom);
    if (pick == 7) begin
      case ($urandom_range(0, 4))
        0:       return VALUE_W'(-65536);
        1:       return VALUE_W'(65535);
        2:       return VALUE_W'(-1);
        3:       return VALUE_W'(CODE_OFFSET);
        default: return '0;
      endcase
    end
    if (cmd == CMD_ENCRYPT) return VALUE_W'($urandom_range(0, 255));
    mag = (n > 1) ? int'($urandom_range(0, n - 1)) : int'($urandom_range(0, 5));
    return VALUE_W'($urandom_range(0, 1) ? -mag : mag);
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Track register writes, predict accepted items, check results
  always @(posedge clk_i) begin
    modexp_out_t             want;
    logic signed [RES_W-1:0] got_res;
    logic signed [CODE_W-1:0] got_code;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got_res  = m_tdata[RES_W-1:0];
        got_code = m_tdata[RES_W +: CODE_W];
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with none awaited", got_res, got_code));
        end else begin
          want = awaited_q.pop_front();
          if (got_res !== want.residue)
            report_mismatch($sformatf("residue %0d, want %0d", got_res, want.residue));
          if (got_code !== want.code)
            report_mismatch($sformatf("out_code %0d, want %0d", got_code, want.code));
        end
      end
      if (s_tvalid && s_tready) begin
        if (tag_typed) awaited_q.push_back(tag_out);
        else awaited_q.push_back(modexp_predict(s_tuser, s_tdata[VALUE_W-1:0],
                                                cur_modulus, cur_enc_exp, cur_dec_exp));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MODULUS: cur_modulus = cfg_wdata;
          REG_ENC_EXP: cur_enc_exp = cfg_wdata;
          REG_DEC_EXP: cur_dec_exp = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold on request
  always begin
    @(posedge clk_i);
    if (hold_req) begin
      hold_req = 1'b0;
      m_tready <= 1'b0;
      for (int c = 0; c < LONG_HOLD_CYCLES; c++) @(posedge clk_i);
    end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offer one item, maybe after an idle burst, and hold it until taken
  task automatic send_item(logic cmd, logic signed [VALUE_W-1:0] value,
                           bit typed, modexp_out_t typed_out);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= cmd;
    s_tdata   <= {{(24 - VALUE_W){1'b0}}, value};
    tag_typed <= typed;
    tag_out   <= typed_out;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Stop offering and wait for every awaited result
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited_q.size() != 0);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [CFG_W-1:0] n, logic [CFG_W-1:0] e_enc,
                            logic [CFG_W-1:0] e_dec);
    write_reg(REG_MODULUS, n);
    write_reg(REG_ENC_EXP, e_enc);
    write_reg(REG_DEC_EXP, e_dec);
    cfg_we <= 1'b0;
  endtask

  // Stimulus
  initial begin
    modexp_out_t              row_out;
    modexp_out_t              pair_out;
    logic [CFG_W-1:0]         ph_mod;
    logic [CFG_W-1:0]         ph_enc;
    logic [CFG_W-1:0]         ph_dec;
    logic                     cmd;
    logic signed [VALUE_W-1:0] code_v;
    int                       sent;
    int                       pct_opts [3];
    pct_opts = '{0, 8, 30};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    tx_idle_pct = 20;
    rx_idle_pct = 10;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        if (!cfg_we) wait_results_drained();
        write_reg(directed[i].reg_idx, CFG_W'(directed[i].value));
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        row_out.residue = RES_W'(directed[i].t_res);
        row_out.code    = CODE_W'(directed[i].t_code);
        send_item(directed[i].cmd, VALUE_W'(directed[i].value), directed[i].typed, row_out);
      end
    end

    // Random phases, each under its own key set
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_results_drained();
      if (ph == 0) ph_mod = 16'hFFFF;
      else if (ph == 1) ph_mod = 16'd2;
      else if (ph == HOLD_PHASE) ph_mod = CFG_W'($urandom_range(3, 400));
      else begin
        case ($urandom_range(0, 7))
          0:       ph_mod = '0;
          1:       ph_mod = 16'd1;
          2:       ph_mod = 16'd2;
          3:       ph_mod = 16'hFFFF;
          4:       ph_mod = CFG_W'($urandom_range(3, 400));
          default: ph_mod = CFG_W'($urandom_range(2, 65535));
        endcase
      end
      if (ph == HOLD_PHASE) begin
        ph_enc = CFG_W'($urandom_range(0, 2));
        ph_dec = CFG_W'($urandom_range(0, 2));
      end else begin
        ph_enc = CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                     : $urandom_range(0, 9));
        ph_dec = CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                     : $urandom_range(0, 9));
      end
      set_config(ph_mod, ph_enc, ph_dec);

      if (ph == NUM_PHASES - 1) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = pct_opts[$urandom_range(0, 2)];
        rx_idle_pct = pct_opts[$urandom_range(0, 2)];
      end
      // fill the block behind a stalled receiver
      if (ph == HOLD_PHASE) begin
        tx_idle_pct = 0;
        hold_req    = 1'b1;
      end

      sent = 0;
      while (sent < RAND_ITEMS / NUM_PHASES) begin
        if ($urandom_range(0, 1)) begin
          // encrypt a code, then decrypt its residue
          code_v   = VALUE_W'($urandom_range(0, 255));
          pair_out = modexp_predict(CMD_ENCRYPT, code_v, ph_mod, ph_enc, ph_dec);
          send_item(CMD_ENCRYPT, code_v, 1'b0, '0);
          send_item(CMD_DECRYPT, pair_out.residue, 1'b0, '0);
          sent += 2;
        end else begin
          cmd = ($urandom_range(0, 1) != 0) ? CMD_DECRYPT : CMD_ENCRYPT;
          send_item(cmd, random_value(cmd, ph_mod), 1'b0, '0);
          sent++;
        end
      end
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
